// ===== sv/assert_macros.svh =====
// Assertion macros shared by the response frame deframer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define RFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define RFD_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define RFD_ASSERT(lbl, clk, rst, prop, msg)
`define RFD_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== sv/rfd_pkg.sv =====
// Shared constants and types of the response frame deframer.
package rfd_pkg;

   // Window buffer size and derived widths.
   localparam int WINDOW_BYTES = 18;
   localparam int FILL_W = $clog2(WINDOW_BYTES + 1);
   localparam int IDX_W = $clog2(WINDOW_BYTES);

   // Frame format.
   localparam logic [7:0] SYNC_BYTE = 8'h53;
   localparam logic [7:0] READ_CMD = 8'h52;
   localparam logic [15:0] STATUS_ADDR = 16'h3008;
   localparam logic [15:0] ANSWER_ADDR_RESET = 16'h3000;
   localparam logic [7:0] ANSWER_WORDS = 8'd6;
   localparam logic [7:0] STATUS_WORDS = 8'd1;
   localparam int HEADER_BYTES = 5;
   localparam int MIN_SCAN = 8;
   localparam int ANSWER_NEED = 6 + 2 * 6;
   localparam int STATUS_NEED = 6 + 2 * 1;

   // Result budget per received byte.
   localparam int MAX_RESULTS = 24;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   // Result queue between scanner and output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Result kinds.
   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [15:0] reg_address;
      logic [2:0]  word_index;
      logic [15:0] data_word;
      logic        last;
   } result_type;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_HUNT,
      SCAN_SUM,
      SCAN_CHECK,
      SCAN_EMIT
   } scan_state_type;

endpackage

// ===== sv/rfd_queue.sv =====
// Short result queue between the frame scanner and the output stage.
`include "assert_macros.svh"
module rfd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  rfd_pkg::result_type push_data,
   output logic               full,
   output logic               head_valid,
   output rfd_pkg::result_type head_data,
   input  logic               pop
);
   import rfd_pkg::*;

   result_type          mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff;
   logic [PTR_W-1:0]    rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push;
   logic                do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && head_valid;

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= PTR_W'(wr_ptr_ff + 1'b1);
         end
         if (do_pop) begin
            rd_ptr_ff <= PTR_W'(rd_ptr_ff + 1'b1);
         end
         if (do_push && !do_pop) begin
            count_ff <= QCNT_W'(count_ff + 1'b1);
         end else if (do_pop && !do_push) begin
            count_ff <= QCNT_W'(count_ff - 1'b1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `RFD_NEVER(a_no_push_when_full, clock, reset, push_valid && full, "result pushed into full queue")
   `RFD_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")

endmodule

// ===== sv/rfd_scan.sv =====
// Front end: byte window, sync hunt, header check, checksum and word split.
`include "assert_macros.svh"
module rfd_scan (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic [15:0]        answer_address,
   output logic               push_valid,
   output rfd_pkg::result_type push_data,
   input  logic               queue_full
);
   import rfd_pkg::*;

   typedef logic [WINDOW_BYTES-1:0][7:0] window_type;

   localparam logic [2:0] DROP_ONE = 3'd1;
   localparam logic [2:0] DROP_WORD = 3'd2;
   localparam logic [2:0] DROP_TAIL = 3'd3;
   localparam logic [2:0] DROP_HEADER = 3'(HEADER_BYTES);

   // Remove amt bytes from the front of the window.
   function automatic window_type shift_window(window_type w, logic [2:0] amt);
      window_type r;
      r = window_type'(w >> {amt, 3'b000});
      return r;
   endfunction

   scan_state_type      state_ff, state_in;
   window_type          win_ff, win_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]    nres_ff, nres_in;
   logic [7:0]          sum_ff, sum_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [15:0]         addr_ff, addr_in;
   logic                long_ff, long_in;
   logic [2:0]          widx_ff, widx_in;
   logic                pend_valid_ff, pend_valid_in;
   result_type          pend_ff, pend_in;

   logic [15:0]         hdr_addr;
   logic                is_answer;
   logic                is_status;
   logic                hdr_ok;
   logic [FILL_W-1:0]   hdr_need;
   logic                limit_hit;
   logic [IDX_W-1:0]    sum_end;
   logic [7:0]          check_byte;
   logic [2:0]          last_widx;
   logic                new_valid;
   result_type          new_res;
   logic                finish;
   logic                stall;

   // Header decode over the front of the window.
   always_comb begin
      hdr_addr = {win_ff[4], win_ff[3]};
      is_answer = (hdr_addr == answer_address) && (win_ff[1] == ANSWER_WORDS);
      is_status = (hdr_addr == STATUS_ADDR) && (win_ff[1] == STATUS_WORDS);
      hdr_ok = (win_ff[2] == READ_CMD) && (is_answer || is_status);
      hdr_need = is_answer ? FILL_W'(ANSWER_NEED) : FILL_W'(STATUS_NEED);
      limit_hit = (nres_ff > CNT_W'(MAX_RESULTS - 6));
      sum_end = long_ff ? IDX_W'(ANSWER_NEED - 2) : IDX_W'(STATUS_NEED - 2);
      check_byte = long_ff ? win_ff[ANSWER_NEED - 1] : win_ff[STATUS_NEED - 1];
      last_widx = long_ff ? 3'(ANSWER_WORDS - 8'd1) : 3'(STATUS_WORDS - 8'd1);
   end

   // Scan sequencer: next state, window updates and result hand-off.
   always_comb begin
      state_in = state_ff;
      win_in = win_ff;
      fill_in = fill_ff;
      nres_in = nres_ff;
      sum_in = sum_ff;
      idx_in = idx_ff;
      addr_in = addr_ff;
      long_in = long_ff;
      widx_in = widx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      new_valid = 1'b0;
      new_res = '0;
      finish = 1'b0;
      req_ready = (state_ff == SCAN_IDLE);

      // Decide what this cycle wants to produce.
      case (state_ff)
         SCAN_HUNT: begin
            if (limit_hit || fill_ff == '0) begin
               finish = 1'b1;
            end else if (win_ff[0] == SYNC_BYTE && fill_ff >= FILL_W'(MIN_SCAN) && hdr_ok &&
                         fill_ff < hdr_need) begin
               finish = 1'b1;
            end else if (win_ff[0] == SYNC_BYTE && fill_ff < FILL_W'(MIN_SCAN)) begin
               finish = 1'b1;
            end
         end
         SCAN_CHECK: begin
            if (sum_ff != check_byte) begin
               new_valid = 1'b1;
               new_res.kind = KIND_ERROR;
               new_res.reg_address = addr_ff;
            end
         end
         SCAN_EMIT: begin
            new_valid = 1'b1;
            new_res.kind = KIND_DATA;
            new_res.reg_address = addr_ff;
            new_res.word_index = widx_ff;
            new_res.data_word = {win_ff[1], win_ff[0]};
         end
         default: begin
         end
      endcase

      stall = (new_valid || finish) && pend_valid_ff && queue_full;
      push_valid = (new_valid || finish) && pend_valid_ff && !queue_full;
      push_data = pend_ff;
      push_data.last = finish;

      if (!stall) begin
         // Hold back the newest result so the final one can carry last.
         if (new_valid) begin
            pend_in = new_res;
            pend_valid_in = 1'b1;
            nres_in = CNT_W'(nres_ff + 1'b1);
         end else if (finish) begin
            pend_valid_in = 1'b0;
         end

         case (state_ff)
            SCAN_IDLE: begin
               if (req_valid) begin
                  if (fill_ff == FILL_W'(WINDOW_BYTES)) begin
                     win_in = shift_window(win_ff, DROP_ONE);
                     win_in[WINDOW_BYTES - 1] = req_rx_byte;
                  end else begin
                     win_in[fill_ff[IDX_W-1:0]] = req_rx_byte;
                     fill_in = FILL_W'(fill_ff + 1'b1);
                  end
                  nres_in = '0;
                  state_in = SCAN_HUNT;
               end
            end
            SCAN_HUNT: begin
               if (finish) begin
                  state_in = SCAN_IDLE;
               end else if (win_ff[0] != SYNC_BYTE || !hdr_ok) begin
                  win_in = shift_window(win_ff, DROP_ONE);
                  fill_in = FILL_W'(fill_ff - 1'b1);
               end else begin
                  addr_in = hdr_addr;
                  long_in = is_answer;
                  sum_in = '0;
                  idx_in = '0;
                  state_in = SCAN_SUM;
               end
            end
            SCAN_SUM: begin
               sum_in = 8'(sum_ff + win_ff[idx_ff]);
               idx_in = IDX_W'(idx_ff + 1'b1);
               if (idx_ff == sum_end) begin
                  state_in = SCAN_CHECK;
               end
            end
            SCAN_CHECK: begin
               if (new_valid) begin
                  win_in = shift_window(win_ff, DROP_ONE);
                  fill_in = FILL_W'(fill_ff - 1'b1);
                  state_in = SCAN_HUNT;
               end else begin
                  win_in = shift_window(win_ff, DROP_HEADER);
                  fill_in = FILL_W'(fill_ff - FILL_W'(DROP_HEADER));
                  widx_in = '0;
                  state_in = SCAN_EMIT;
               end
            end
            SCAN_EMIT: begin
               if (widx_ff == last_widx) begin
                  win_in = shift_window(win_ff, DROP_TAIL);
                  fill_in = FILL_W'(fill_ff - FILL_W'(DROP_TAIL));
                  state_in = SCAN_HUNT;
               end else begin
                  win_in = shift_window(win_ff, DROP_WORD);
                  fill_in = FILL_W'(fill_ff - FILL_W'(DROP_WORD));
                  widx_in = 3'(widx_ff + 1'b1);
               end
            end
            default: begin
               state_in = SCAN_IDLE;
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SCAN_IDLE;
         fill_ff <= '0;
         pend_valid_ff <= 1'b0;
         nres_ff <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff <= fill_in;
         pend_valid_ff <= pend_valid_in;
         nres_ff <= nres_in;
      end
   end

   // Window bytes and working registers.
   always_ff @(posedge clock) begin
      win_ff <= win_in;
      sum_ff <= sum_in;
      idx_ff <= idx_in;
      addr_ff <= addr_in;
      long_ff <= long_in;
      widx_ff <= widx_in;
      pend_ff <= pend_in;
   end

   `RFD_ASSERT(a_fill_bound, clock, reset, fill_ff <= FILL_W'(WINDOW_BYTES), "window fill overflow")
   `RFD_ASSERT(a_idle_flushed, clock, reset, (state_ff == SCAN_IDLE) |-> !pend_valid_ff, "result left pending at idle")
   `RFD_ASSERT(a_emit_has_bytes, clock, reset, (state_ff == SCAN_EMIT) |-> (fill_ff >= FILL_W'(DROP_TAIL)), "payload emit on short window")

endmodule

// ===== sv/rfd_emit.sv =====
// Back end: output register that presents one result item at a time.
module rfd_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  rfd_pkg::result_type head_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rfd_pkg::result_type rsp_data
);
   import rfd_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Load a new item when the register is empty or being taken.
   assign pop = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= head_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

endmodule

// ===== sv/response_frame_deframer_top.sv =====
// Top level of the response frame deframer: address register and unit wiring.
//
// Each received byte is appended to an 18-byte window and the scanner then
// works over the window one step per cycle while it is not stalled: it drops
// non-sync bytes and rejected headers one per cycle, adds a complete frame's
// checksum one byte per cycle, checks it in the check state and, unless the
// queue is full, splits off one payload word per cycle. A new byte is taken
// only in the idle state; each byte is worked on in the hunt state and, if it
// completes a frame, in the sum, check and emit states before the next byte
// is accepted. Results pass through a four-entry queue and an output
// register, so the scanner only waits on the output side when the queue is
// full. The last flag marks the final result caused by one byte.
// answer_address may only be written while no byte is being worked on.
module response_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [15:0] rsp_reg_address,
   output logic [2:0]  rsp_word_index,
   output logic [15:0] rsp_data_word,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);
   import rfd_pkg::*;

   logic [15:0] answer_address_ff;
   logic        push_valid;
   result_type  push_data;
   logic        queue_full;
   logic        head_valid;
   result_type  head_data;
   logic        pop;
   result_type  rsp_data;

   // Answer address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         answer_address_ff <= ANSWER_ADDR_RESET;
      end else if (csr_write_enable) begin
         answer_address_ff <= csr_write_data;
      end
   end

   rfd_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_rx_byte    (req_rx_byte),
      .answer_address (answer_address_ff),
      .push_valid     (push_valid),
      .push_data      (push_data),
      .queue_full     (queue_full)
   );

   rfd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   rfd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // Result fields onto their own ports.
   assign rsp_kind = rsp_data.kind;
   assign rsp_reg_address = rsp_data.reg_address;
   assign rsp_word_index = rsp_data.word_index;
   assign rsp_data_word = rsp_data.data_word;
   assign rsp_last = rsp_data.last;

endmodule

// ===== verif/response_frame_deframer_checker.sv =====
// Checker for the response frame deframer: predicts results per received byte and compares them.
module response_frame_deframer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_kind,
   input  logic [15:0] rsp_reg_address,
   input  logic [2:0]  rsp_word_index,
   input  logic [15:0] rsp_data_word,
   input  logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data,
   output int          outstanding,
   output int          mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import rfd_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the receive window and the answer address register.
   logic [7:0]  shadow_window [WINDOW_BYTES];
   int          shadow_fill;
   logic [15:0] shadow_answer_address;

   // Results still owed by the block, oldest first.
   result_type  awaited_results [$];

   initial begin
      outstanding = 0;
      mismatch_count = 0;
      shadow_fill = 0;
      shadow_answer_address = ANSWER_ADDR_RESET;
   end

   // Remove bytes from the front of the shadow window.
   function automatic void discard_front(int count);
      int i;
      if (count >= shadow_fill) begin
         shadow_fill = 0;
      end else begin
         for (i = 0; i < shadow_fill - count; i++) begin
            shadow_window[i] = shadow_window[i + count];
         end
         shadow_fill -= count;
      end
   endfunction

   // Append one byte and rescan the window, queueing every result this byte causes.
   function automatic void deframe_byte(logic [7:0] rx_byte);
      result_type  made [$];
      result_type  entry;
      logic [7:0]  frame_len;
      logic [7:0]  frame_cmd;
      logic [15:0] frame_addr;
      logic [7:0]  frame_sum;
      int          need;
      int          i;
      bit          header_ok;

      if (shadow_fill >= WINDOW_BYTES) discard_front(1);
      shadow_window[shadow_fill] = rx_byte;
      shadow_fill++;

      forever begin
         // Stop while there is no room left for a full answer frame.
         if (made.size() + int'(ANSWER_WORDS) > MAX_RESULTS) break;

         // Hunt for a sync byte.
         while (shadow_fill > 0 && shadow_window[0] != SYNC_BYTE) discard_front(1);
         if (shadow_fill < MIN_SCAN) break;

         frame_len  = shadow_window[1];
         frame_cmd  = shadow_window[2];
         frame_addr = {shadow_window[4], shadow_window[3]};
         header_ok  = (frame_cmd == READ_CMD) &&
                      ((frame_addr == shadow_answer_address && frame_len == ANSWER_WORDS) ||
                       (frame_addr == STATUS_ADDR && frame_len == STATUS_WORDS));
         if (!header_ok) begin
            discard_front(1);
            continue;
         end

         // Wait until the whole frame is buffered.
         need = 6 + 2 * int'(frame_len);
         if (need > WINDOW_BYTES || shadow_fill < need) break;

         frame_sum = 8'h00;
         for (i = 0; i < need - 1; i++) frame_sum += shadow_window[i];

         // A bad checksum reports the frame and slips one byte.
         if (frame_sum != shadow_window[need - 1]) begin
            entry.kind        = KIND_ERROR;
            entry.reg_address = frame_addr;
            entry.word_index  = 3'd0;
            entry.data_word   = 16'h0000;
            entry.last        = 1'b0;
            made.push_back(entry);
            discard_front(1);
            continue;
         end

         // A good frame gives one item per payload word.
         for (i = 0; i < int'(frame_len); i++) begin
            entry.kind        = KIND_DATA;
            entry.reg_address = frame_addr;
            entry.word_index  = i[2:0];
            entry.data_word   = {shadow_window[6 + 2 * i], shadow_window[5 + 2 * i]};
            entry.last        = 1'b0;
            made.push_back(entry);
         end
         discard_front(need);
      end

      if (made.size() > 0) made[made.size() - 1].last = 1'b1;
      foreach (made[k]) awaited_results.push_back(made[k]);
   endfunction

   // Count a failure and describe the first few.
   function automatic void record_failure(string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) $display("%t mismatch: %s", $realtime, what);
   endfunction

   // Results are checked before the byte of the same edge is predicted,
   // since a result can never come from a byte accepted at that edge.
   always @(posedge clock) begin : watch
      result_type want;
      if (reset) begin
         shadow_fill = 0;
         shadow_answer_address = ANSWER_ADDR_RESET;
         awaited_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_results.size() == 0) begin
               record_failure($sformatf(
                  "unexpected item kind=%0d addr=%h idx=%0d data=%h last=%0d",
                  rsp_kind, rsp_reg_address, rsp_word_index, rsp_data_word, rsp_last));
            end else begin
               want = awaited_results.pop_front();
               if (want.kind !== rsp_kind || want.reg_address !== rsp_reg_address ||
                   want.word_index !== rsp_word_index ||
                   want.data_word !== rsp_data_word || want.last !== rsp_last) begin
                  record_failure($sformatf(
                     "expected kind=%0d addr=%h idx=%0d data=%h last=%0d, got %0d %h %0d %h %0d",
                     want.kind, want.reg_address, want.word_index, want.data_word,
                     want.last, rsp_kind, rsp_reg_address, rsp_word_index,
                     rsp_data_word, rsp_last));
               end
            end
         end
         if (csr_write_enable) shadow_answer_address = csr_write_data;
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
      end
      outstanding <= awaited_results.size();
   end

endmodule

// ===== verif/tb_response_frame_deframer_top.sv =====
// Testbench top for the response frame deframer: clock, reset, byte stimulus and verdict.
module tb_response_frame_deframer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rfd_pkg::*;

   localparam int RUN_LIMIT     = 400000;
   localparam int SETTLE_CYCLES = 500;
   localparam int PHASE_BYTES   = 40;
   localparam int PHASE_COUNT   = 6;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [15:0] rsp_reg_address;
   logic [2:0]  rsp_word_index;
   logic [15:0] rsp_data_word;
   logic        rsp_last;
   logic        csr_write_enable = 1'b0;
   logic [15:0] csr_write_data = 16'h0000;

   int          outstanding;
   int          mismatch_count;
   int          cycle_count = 0;
   int          rsp_stall = 0;
   bit          rsp_quiet = 1'b0;
   logic [15:0] answer_setting = ANSWER_ADDR_RESET;
   logic [7:0]  link_bytes [$];

   // Clock generation.
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   response_frame_deframer_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_reg_address  (rsp_reg_address),
      .rsp_word_index   (rsp_word_index),
      .rsp_data_word    (rsp_data_word),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   response_frame_deframer_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_reg_address  (rsp_reg_address),
      .rsp_word_index   (rsp_word_index),
      .rsp_data_word    (rsp_data_word),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .outstanding      (outstanding),
      .mismatch_count   (mismatch_count)
   );

   // Result side: a random stall after each item, with stretches of none.
   always @(posedge clock) begin : rsp_pacing
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 39) == 0) rsp_quiet <= !rsp_quiet;
         stall = rsp_quiet ? 0 : $urandom_range(0, 14);
         if (stall != 0) rsp_ready <= 1'b0;
         rsp_stall <= stall;
      end else if (!rsp_ready) begin
         if (rsp_stall <= 1) rsp_ready <= 1'b1;
         rsp_stall <= rsp_stall - 1;
      end
   end

   // Payload bytes lean toward the extremes and the sync value.
   function automatic logic [7:0] payload_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return SYNC_BYTE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Queue a read response frame, with a correct or a spoiled checksum.
   task automatic queue_frame(input logic [15:0] addr, input logic [7:0] words,
                              input bit corrupt);
      logic [7:0] sum;
      logic [7:0] data;
      int         k;
      link_bytes.push_back(SYNC_BYTE);
      link_bytes.push_back(words);
      link_bytes.push_back(READ_CMD);
      link_bytes.push_back(addr[7:0]);
      link_bytes.push_back(addr[15:8]);
      sum = SYNC_BYTE + words + READ_CMD + addr[7:0] + addr[15:8];
      for (k = 0; k < 2 * int'(words); k++) begin
         data = payload_byte();
         link_bytes.push_back(data);
         sum += data;
      end
      if (corrupt) sum += 8'($urandom_range(1, 255));
      link_bytes.push_back(sum);
   endtask

   // Queue one random piece of link traffic; counted gives its frame bytes.
   task automatic queue_random_chunk(output int counted);
      int          pick;
      int          start;
      int          spot;
      logic [7:0]  words;
      logic [15:0] addr;
      start = link_bytes.size();
      pick  = $urandom_range(0, 99);
      words = $urandom_range(0, 1) ? ANSWER_WORDS : STATUS_WORDS;
      addr  = (words == ANSWER_WORDS) ? answer_setting : STATUS_ADDR;
      if (pick < 35) begin
         queue_frame(answer_setting, ANSWER_WORDS, 1'b0);
      end else if (pick < 55) begin
         queue_frame(STATUS_ADDR, STATUS_WORDS, 1'b0);
      end else if (pick < 65) begin
         queue_frame(addr, words, 1'b1);
      end else if (pick < 77) begin
         // Spoil one header byte after the sync.
         queue_frame(addr, words, 1'b0);
         spot = start + $urandom_range(1, 4);
         link_bytes[spot] = link_bytes[spot] ^ 8'($urandom_range(1, 255));
      end else if (pick < 87) begin
         // Cut the frame short; the following traffic runs into it.
         queue_frame(addr, words, 1'b0);
         repeat ($urandom_range(1, link_bytes.size() - start - 1)) void'(link_bytes.pop_back());
      end else begin
         repeat ($urandom_range(1, 4)) link_bytes.push_back(8'($urandom_range(0, 255)));
      end
      counted = (pick < 87) ? link_bytes.size() - start : 0;
   endtask

   // Send every queued byte; valid stays high after the last one until lowered.
   task automatic send_link(input bit quiet);
      logic [7:0] data;
      int         gap;
      while (link_bytes.size() > 0) begin
         data = link_bytes.pop_front();
         gap  = quiet ? 0 : $urandom_range(0, 14);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid   <= 1'b1;
         req_rx_byte <= data;
         do @(posedge clock); while (!req_ready);
      end
   endtask

   // Wait until every predicted item has come back.
   task automatic wait_drained();
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Let the block go idle, then write the answer address.
   task automatic set_answer_address(input logic [15:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      answer_setting = value;
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      int phase;
      int phase_bytes;
      int counted;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: byte extremes, a lone sync with a rejected header, a good
      // status frame and a status frame with a bad checksum.
      link_bytes.push_back(8'h00);
      link_bytes.push_back(8'hFF);
      link_bytes.push_back(SYNC_BYTE);
      queue_frame(STATUS_ADDR, STATUS_WORDS, 1'b0);
      queue_frame(STATUS_ADDR, STATUS_WORDS, 1'b1);
      send_link(1'b0);

      // Random traffic under several answer addresses, including the status
      // address itself so both frame lengths match there.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase > 0) begin
            req_valid <= 1'b0;
            case (phase)
               1:       set_answer_address(16'h0000);
               2:       set_answer_address(16'hFFFF);
               3:       set_answer_address(STATUS_ADDR);
               default: set_answer_address(16'($urandom_range(0, 65535)));
            endcase
         end
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            queue_random_chunk(counted);
            phase_bytes += counted;
            send_link($urandom_range(0, 3) == 0);
         end
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Run limit.
   initial begin
      while (cycle_count < RUN_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== response_frame_deframer_top.f =====
+incdir+sv
sv/rfd_pkg.sv
sv/rfd_queue.sv
sv/rfd_scan.sv
sv/rfd_emit.sv
sv/response_frame_deframer_top.sv
verif/response_frame_deframer_checker.sv
verif/tb_response_frame_deframer_top.sv
